// ----- hdl/slfr_pkg.sv -----
// Shared widths, register indexes and status codes of the frame receiver.
`default_nettype none
package slfr_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned AddrW    = 32;
  localparam int unsigned LenW     = 16;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // message header length in bytes
  localparam logic [LenW-1:0] HdrBytes = 16'd16;

  // register reset values
  localparam logic [LenW-1:0] FrameLimitRst = 16'd512;
  localparam logic [LenW-1:0] SyncWordRst   = 16'hbe57;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgFrameLimit = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSyncWord   = 2'd1;

  // closing status codes
  localparam logic [StatusW-1:0] StOk        = 3'd0;
  localparam logic [StatusW-1:0] StTooLong   = 3'd1;
  localparam logic [StatusW-1:0] StBadType   = 3'd2;
  localparam logic [StatusW-1:0] StPayBig    = 3'd3;
  localparam logic [StatusW-1:0] StTooShort  = 3'd4;

endpackage
`default_nettype wire

// ----- hdl/slfr_if.sv -----
// Valid/ready channels for received bytes and for result words.
`default_nettype none
interface slfr_in_if;
  logic                        valid;
  logic                        ready;
  logic [slfr_pkg::ByteW-1:0]  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slfr_out_if;
  logic                          valid;
  logic                          ready;
  logic [slfr_pkg::ByteW-1:0]    payload_byte;
  logic                          data_valid;
  logic [slfr_pkg::AddrW-1:0]    source_address;
  logic [slfr_pkg::AddrW-1:0]    dest_address;
  logic [slfr_pkg::LenW-1:0]     payload_length;
  logic [slfr_pkg::LenW-1:0]     message_flags;
  logic                          last;
  logic [slfr_pkg::StatusW-1:0]  status;

  modport source (output valid, output payload_byte, output data_valid,
                  output source_address, output dest_address, output payload_length,
                  output message_flags, output last, output status, input ready);
  modport sink   (input valid, input payload_byte, input data_valid,
                  input source_address, input dest_address, input payload_length,
                  input message_flags, input last, input status, output ready);
endinterface
`default_nettype wire

// ----- hdl/sync_length_frame_receiver_core.sv -----
// Top level of the sync word / length prefixed frame receiver.
`default_nettype none
// Receives one byte per word on in_ch, hunts for a 16-bit sync word (low byte
// first), reads the link header (sync, 16-bit frame length, type) and the
// 16-byte little-endian message header (source, destination, reserved,
// payload length, flags), then streams payload bytes on out_ch tagged with
// the header fields. The last byte of a frame, or any header error, yields a
// word with last set and a status; the receiver then goes back to the hunt.
// Header-only frames close on the final header byte; slack bytes after the
// payload produce no word except the final one (data_valid low).
// Throughput: one byte per clock when not stalled. A byte goes into an input
// register, is decoded combinationally by the parser against the header state
// and lands in the output register, which drives out_ch.valid.
// The output register has its own valid, so while a word waits the input
// register can still take one more byte; the only stall is out_ch.ready low
// with both the input and output registers full. Configuration (frame_limit
// at index 0, sync_word at index 1, other indexes ignored) must be written
// only while idle; the block itself does not enforce this.
module sync_length_frame_receiver_core (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire [slfr_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire [slfr_pkg::CfgDataW-1:0]   cfg_data_i,
  slfr_in_if.sink                        in_ch,
  slfr_out_if.source                     out_ch
);
  import slfr_pkg::*;

  // parser phases
  localparam logic [2:0] PhHuntEmpty = 3'd0;  // no byte held yet
  localparam logic [2:0] PhHunt      = 3'd1;
  localparam logic [2:0] PhLink      = 3'd2;
  localparam logic [2:0] PhMhdr      = 3'd3;
  localparam logic [2:0] PhBody      = 3'd4;

  // configuration
  logic [LenW-1:0] frame_limit_q, sync_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_limit_q <= FrameLimitRst;
      sync_word_q   <= SyncWordRst;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CfgFrameLimit) frame_limit_q <= cfg_data_i;
      if (cfg_index_i == CfgSyncWord)   sync_word_q   <= cfg_data_i;
    end
  end

  // input register
  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             fire;

  assign fire        = in_valid_q && (!out_ch.valid || out_ch.ready);
  assign in_ch.ready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) in_byte_q <= in_ch.rx_byte;
  end

  // parser state
  logic [2:0]       phase_q, phase_d;
  logic [ByteW-1:0] prev_q, prev_d;
  logic [1:0]       lcnt_q, lcnt_d;     // link header byte after sync: len lo, len hi, type
  logic [LenW-1:0]  flen_q, flen_d;
  logic [LenW-1:0]  fbc_q, fbc_d;       // frame byte count from message header start
  logic [AddrW-1:0] src_q, src_d;
  logic [AddrW-1:0] dst_q, dst_d;
  logic [LenW-1:0]  plen_q, plen_d;
  logic [LenW-1:0]  flags_q, flags_d;

  // result decode
  logic               emit;
  logic [ByteW-1:0]   r_byte;
  logic               r_dv;
  logic               r_last;
  logic [StatusW-1:0] r_status;

  logic [3:0]         hidx;
  logic [LenW:0]      pay_end;
  logic [LenW:0]      fbc_next;
  logic               is_payload;
  logic               is_last;
  logic [ByteW-1:0]   b;

  assign b          = in_byte_q;
  assign hidx       = fbc_q[3:0];
  assign pay_end    = {1'b0, HdrBytes} + {1'b0, plen_q};
  assign fbc_next   = {1'b0, fbc_q} + 17'd1;
  assign is_payload = {1'b0, fbc_q} < pay_end;
  assign is_last    = fbc_next >= {1'b0, flen_q};

  always_comb begin
    phase_d  = phase_q;
    prev_d   = prev_q;
    lcnt_d   = lcnt_q;
    flen_d   = flen_q;
    fbc_d    = fbc_q;
    src_d    = src_q;
    dst_d    = dst_q;
    plen_d   = plen_q;
    flags_d  = flags_q;
    emit     = 1'b0;
    r_byte   = '0;
    r_dv     = 1'b0;
    r_last   = 1'b0;
    r_status = StOk;
    unique case (phase_q)
      PhHuntEmpty: begin
        prev_d  = b;
        phase_d = PhHunt;
      end
      PhHunt: begin
        if ({b, prev_q} == sync_word_q) begin
          phase_d = PhLink;
          lcnt_d  = 2'd0;
          flen_d  = '0;
          fbc_d   = '0;
          src_d   = '0;
          dst_d   = '0;
          plen_d  = '0;
          flags_d = '0;
        end
        prev_d = b;
      end
      PhLink: begin
        if (lcnt_q == 2'd0) begin
          flen_d[7:0] = b;
          lcnt_d      = 2'd1;
        end else if (lcnt_q == 2'd1) begin
          flen_d[15:8] = b;
          lcnt_d       = 2'd2;
        end else begin
          // type byte: run the link header checks in order
          lcnt_d = 2'd0;
          fbc_d  = '0;
          if (flen_q > frame_limit_q) begin
            emit = 1'b1; r_last = 1'b1; r_status = StTooLong;
            phase_d = PhHuntEmpty;
          end else if (flen_q < HdrBytes) begin
            emit = 1'b1; r_last = 1'b1; r_status = StTooShort;
            phase_d = PhHuntEmpty;
          end else if (b != '0) begin
            emit = 1'b1; r_last = 1'b1; r_status = StBadType;
            phase_d = PhHuntEmpty;
          end else begin
            phase_d = PhMhdr;
          end
        end
      end
      PhMhdr: begin
        unique case (hidx[3:2])
          2'd0: src_d[{hidx[1:0], 3'b000} +: 8] = b;
          2'd1: dst_d[{hidx[1:0], 3'b000} +: 8] = b;
          2'd2: ;  // reserved word
          2'd3: begin
            if (!hidx[1]) plen_d[{hidx[0], 3'b000} +: 8]  = b;
            else          flags_d[{hidx[0], 3'b000} +: 8] = b;
          end
          default: ;
        endcase
        fbc_d = fbc_next[LenW-1:0];
        if (hidx == 4'd15) begin
          if (plen_q > flen_q - HdrBytes) begin
            emit = 1'b1; r_last = 1'b1; r_status = StPayBig;
            phase_d = PhHuntEmpty;
          end else if (flen_q == HdrBytes) begin
            // header-only frame
            emit = 1'b1; r_last = 1'b1; r_status = StOk;
            phase_d = PhHuntEmpty;
          end else begin
            phase_d = PhBody;
          end
        end
      end
      PhBody: begin
        fbc_d = fbc_next[LenW-1:0];
        if (is_last) begin
          emit   = 1'b1;
          r_last = 1'b1;
          r_dv   = is_payload;
          r_byte = is_payload ? b : '0;
          phase_d = PhHuntEmpty;
        end else if (is_payload) begin
          emit   = 1'b1;
          r_dv   = 1'b1;
          r_byte = b;
        end
      end
      default: begin
        phase_d = PhHuntEmpty;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHuntEmpty;
      prev_q  <= '0;
      lcnt_q  <= '0;
      flen_q  <= '0;
      fbc_q   <= '0;
      src_q   <= '0;
      dst_q   <= '0;
      plen_q  <= '0;
      flags_q <= '0;
    end else if (fire) begin
      phase_q <= phase_d;
      prev_q  <= prev_d;
      lcnt_q  <= lcnt_d;
      flen_q  <= flen_d;
      fbc_q   <= fbc_d;
      src_q   <= src_d;
      dst_q   <= dst_d;
      plen_q  <= plen_d;
      flags_q <= flags_d;
    end
  end

  // output register; header fields carry the values after this byte
  logic               out_valid_q;
  logic [ByteW-1:0]   o_byte_q;
  logic               o_dv_q;
  logic [AddrW-1:0]   o_src_q, o_dst_q;
  logic [LenW-1:0]    o_plen_q, o_flags_q;
  logic               o_last_q;
  logic [StatusW-1:0] o_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ch.ready) begin
      out_valid_q <= fire && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      o_byte_q   <= r_byte;
      o_dv_q     <= r_dv;
      o_src_q    <= src_d;
      o_dst_q    <= dst_d;
      o_plen_q   <= plen_d;
      o_flags_q  <= flags_d;
      o_last_q   <= r_last;
      o_status_q <= r_status;
    end
  end

  assign out_ch.valid          = out_valid_q;
  assign out_ch.payload_byte   = o_byte_q;
  assign out_ch.data_valid     = o_dv_q;
  assign out_ch.source_address = o_src_q;
  assign out_ch.dest_address   = o_dst_q;
  assign out_ch.payload_length = o_plen_q;
  assign out_ch.message_flags  = o_flags_q;
  assign out_ch.last           = o_last_q;
  assign out_ch.status         = o_status_q;

`ifndef ASSERT_OFF
  // an error status only ever closes a frame
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.status != StOk |-> out_ch.last)
    else $error("error status without last");

  // payload byte is zero when no data is carried
  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && !out_ch.data_valid |-> out_ch.payload_byte == '0)
    else $error("payload byte set without data_valid");

  // a closing word sends the parser back to the hunt
  a_close_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && emit && r_last |=> phase_q == PhHuntEmpty)
    else $error("parser not hunting after frame close");

  // a word is never dropped: a held word stays while not taken
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(o_last_q))
    else $error("pending result word lost");
`endif

endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the sync word / length prefixed frame receiver.
module tb_top;
  import slfr_pkg::*;

  localparam int ClkHalf      = 4;     // 8 ns period
  localparam int ResetCycles  = 11;
  localparam int SettleCycles = 8;     // input reg + parser + output reg, with margin
  localparam int QuietLimit   = 2000;  // cycles with no word moving on either channel
  localparam int RandomBytes  = 560;   // frame bytes over all random rounds

  // indexes that map to no register
  localparam logic [CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 2'd3;
  // the only message type the receiver takes
  localparam logic [7:0] TypeData = 8'd0;

  typedef enum logic [2:0] {
    PhHuntEmpty,  // hunting, nothing held yet
    PhHunt,       // hunting, one byte held
    PhLink,       // link header after the sync word
    PhMsgHdr,     // 16-byte message header
    PhBody        // payload and slack
  } rx_phase_e;

  typedef struct packed {
    logic [ByteW-1:0]   payload_byte;
    logic               data_valid;
    logic [AddrW-1:0]   source_address;
    logic [AddrW-1:0]   dest_address;
    logic [LenW-1:0]    payload_length;
    logic [LenW-1:0]    message_flags;
    logic               last;
    logic [StatusW-1:0] status;
  } rx_word_t;

  typedef struct {
    logic [15:0] flen;
    logic [7:0]  mtype;
    logic [31:0] src;
    logic [31:0] dst;
    logic [31:0] rsv;
    logic [15:0] plen;
    logic [15:0] flags;
    int          cut;  // bytes to send before breaking off, -1 for the whole frame
  } frame_t;

  logic                clk_i  = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  slfr_in_if  in_ch ();
  slfr_out_if out_ch ();

  sync_length_frame_receiver_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  always begin
    #ClkHalf clk_i = 1'b1;
    #ClkHalf clk_i = 1'b0;
  end

  // Idling knobs, percent per cycle.
  int gap_pct   = 0;
  int stall_pct = 0;

  // Bookkeeping.
  rx_word_t pending_words[$];
  int       mismatches   = 0;
  int       bytes_fed    = 0;
  int       frame_bytes  = 0;
  int       words_checked = 0;
  int       closes_by_status[8];
  int       quiet_cycles = 0;

  // Shadow of the deframer: register copies and parse state.
  logic [15:0] frame_limit_m = FrameLimitRst;
  logic [15:0] sync_word_m   = SyncWordRst;
  rx_phase_e   rx_phase      = PhHuntEmpty;
  logic [7:0]  held_byte     = 8'h00;
  logic [2:0]  link_count    = 3'd0;
  logic [15:0] frame_len     = 16'h0;
  logic [7:0]  type_byte     = 8'h00;
  logic [15:0] body_count    = 16'h0;
  logic [31:0] hdr_src       = 32'h0;
  logic [31:0] hdr_dst       = 32'h0;
  logic [15:0] hdr_plen      = 16'h0;
  logic [15:0] hdr_flags     = 16'h0;

  // Advances the shadow deframer by one accepted byte and queues the word it yields.
  function automatic void deframe_byte(input logic [7:0] b);
    logic [3:0]  pos;
    logic [16:0] payload_end;
    logic        is_payload;
    logic        is_last;
    logic        emit;
    logic        close;
    logic [2:0]  st;
    logic [7:0]  pbyte;
    logic        pvalid;
    rx_word_t    w;
    emit   = 1'b0;
    close  = 1'b0;
    st     = StOk;
    pbyte  = 8'h00;
    pvalid = 1'b0;
    case (rx_phase)
      PhHuntEmpty: begin
        // first byte of a hunt is only held
        held_byte = b;
        rx_phase  = PhHunt;
      end
      PhHunt: begin
        if ({b, held_byte} == sync_word_m) begin
          rx_phase   = PhLink;
          link_count = 3'd2;
          frame_len  = '0;
          type_byte  = '0;
          body_count = '0;
          hdr_src    = '0;
          hdr_dst    = '0;
          hdr_plen   = '0;
          hdr_flags  = '0;
        end
        held_byte = b;
      end
      PhLink: begin
        if (link_count == 3'd2) begin
          frame_len  = {8'h00, b};
          link_count = 3'd3;
        end else if (link_count == 3'd3) begin
          frame_len[15:8] = b;
          link_count      = 3'd4;
        end else begin
          type_byte  = b;
          link_count = 3'd0;
          // too long wins over too short, which wins over bad type
          if (frame_len > frame_limit_m) begin
            close = 1'b1;
            st    = StTooLong;
          end else if (frame_len < HdrBytes) begin
            close = 1'b1;
            st    = StTooShort;
          end else if (type_byte != TypeData) begin
            close = 1'b1;
            st    = StBadType;
          end else begin
            rx_phase   = PhMsgHdr;
            body_count = '0;
          end
        end
      end
      PhMsgHdr: begin
        pos = body_count[3:0];
        if (pos < 4'd4) hdr_src = hdr_src | ({24'h0, b} << (8 * pos[1:0]));
        else if (pos < 4'd8) hdr_dst = hdr_dst | ({24'h0, b} << (8 * pos[1:0]));
        else if (pos == 4'd12 || pos == 4'd13) hdr_plen = hdr_plen | ({8'h0, b} << (8 * pos[0]));
        else if (pos == 4'd14 || pos == 4'd15) hdr_flags = hdr_flags | ({8'h0, b} << (8 * pos[0]));
        body_count = body_count + 16'd1;
        if (pos == 4'd15) begin
          if (hdr_plen > frame_len - HdrBytes) begin
            close = 1'b1;
            st    = StPayBig;
          end else if (frame_len == HdrBytes) begin
            close = 1'b1;  // header-only frame
          end else begin
            rx_phase = PhBody;
          end
        end
      end
      PhBody: begin
        payload_end = 17'(HdrBytes) + 17'(hdr_plen);
        is_payload  = {1'b0, body_count} < payload_end;
        is_last     = ({1'b0, body_count} + 17'd1) >= {1'b0, frame_len};
        body_count  = body_count + 16'd1;
        pbyte       = is_payload ? b : 8'h00;
        pvalid      = is_payload;
        // slack bytes are silent except the closing one
        if (is_last) close = 1'b1;
        else emit = is_payload;
      end
      default: rx_phase = PhHuntEmpty;
    endcase
    if (emit || close) begin
      w.payload_byte   = pbyte;
      w.data_valid     = pvalid;
      w.source_address = hdr_src;
      w.dest_address   = hdr_dst;
      w.payload_length = hdr_plen;
      w.message_flags  = hdr_flags;
      w.last           = close;
      w.status         = close ? st : StOk;
      pending_words.push_back(w);
    end
    if (close) rx_phase = PhHuntEmpty;
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: random backpressure and the word checker.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  rx_word_t seen_word;
  rx_word_t want_word;

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      seen_word = '{payload_byte: out_ch.payload_byte, data_valid: out_ch.data_valid,
                    source_address: out_ch.source_address, dest_address: out_ch.dest_address,
                    payload_length: out_ch.payload_length,
                    message_flags: out_ch.message_flags,
                    last: out_ch.last, status: out_ch.status};
      words_checked++;
      if (seen_word.last === 1'b1) closes_by_status[seen_word.status]++;
      if (pending_words.size() == 0) begin
        mismatches++;
        $display("%0t ns: word %h arrived with nothing expected", $time, seen_word);
      end else begin
        want_word = pending_words.pop_front();
        compare_field("payload_byte", want_word.payload_byte, seen_word.payload_byte);
        compare_field("data_valid", want_word.data_valid, seen_word.data_valid);
        compare_field("source_address", want_word.source_address, seen_word.source_address);
        compare_field("dest_address", want_word.dest_address, seen_word.dest_address);
        compare_field("payload_length", want_word.payload_length, seen_word.payload_length);
        compare_field("message_flags", want_word.message_flags, seen_word.message_flags);
        compare_field("last", want_word.last, seen_word.last);
        compare_field("status", want_word.status, seen_word.status);
      end
    end
  end

  // Watchdog: a run that stops moving words is a failure.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("%0t ns: no word moved for %0d cycles, %0d words still expected",
               $time, quiet_cycles, pending_words.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side.
  // ---------------------------------------------------------------------------

  // One byte on in_ch, with optional idle cycles ahead of it. Returns at the
  // edge that accepts it; valid is left high so back-to-back bytes need no gap.
  task automatic feed_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    deframe_byte(b);
    bytes_fed++;
  endtask

  // Brings the receiver to rest: finishes any open frame with filler, drains
  // every expected word, then lets the pipeline empty of silent bytes.
  task automatic settle();
    while (rx_phase == PhLink || rx_phase == PhMsgHdr || rx_phase == PhBody)
      feed_byte(8'($urandom));
    in_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgFrameLimit) frame_limit_m = val;
    else if (idx == CfgSyncWord) sync_word_m = val;
    @(posedge clk_i);
  endtask

  function automatic frame_t make_frame(input logic [15:0] len, input logic [7:0] mtype,
                                        input logic [15:0] plen);
    frame_t f;
    f.flen  = len;
    f.mtype = mtype;
    f.plen  = plen;
    f.src   = $urandom;
    f.dst   = $urandom;
    f.rsv   = $urandom;
    f.flags = 16'($urandom);
    f.cut   = -1;
    return f;
  endfunction

  // Serializes a frame with the current sync word. Bytes the receiver would
  // only hunt through after a header error are not sent.
  task automatic send_frame(input frame_t f);
    logic [7:0] frame_q[$];
    int         i;
    frame_q = {sync_word_m[7:0], sync_word_m[15:8], f.flen[7:0], f.flen[15:8], f.mtype};
    if (f.flen <= frame_limit_m && f.flen >= HdrBytes && f.mtype == TypeData) begin
      for (i = 0; i < 4; i++) frame_q.push_back(f.src[8*i +: 8]);
      for (i = 0; i < 4; i++) frame_q.push_back(f.dst[8*i +: 8]);
      for (i = 0; i < 4; i++) frame_q.push_back(f.rsv[8*i +: 8]);
      frame_q.push_back(f.plen[7:0]);
      frame_q.push_back(f.plen[15:8]);
      frame_q.push_back(f.flags[7:0]);
      frame_q.push_back(f.flags[15:8]);
      if (f.plen <= f.flen - HdrBytes)
        for (i = HdrBytes; i < f.flen; i++) frame_q.push_back(8'($urandom));
    end
    if (f.cut >= 0)
      while (frame_q.size() > f.cut) void'(frame_q.pop_back());
    for (i = 0; i < frame_q.size(); i++) feed_byte(frame_q[i]);
    frame_bytes += frame_q.size();
  endtask

  // Mostly short frames, a few long ones, never above the limit.
  function automatic logic [15:0] pick_length();
    int r;
    int len;
    r = $urandom_range(0, 99);
    if (r < 90) len = $urandom_range(16, 48);
    else if (r < 98) len = $urandom_range(49, 200);
    else len = $urandom_range(201, 600);
    if (len > frame_limit_m) len = frame_limit_m;
    return 16'(len);
  endfunction

  function automatic logic [15:0] pick_payload(input logic [15:0] room);
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return room;
    if (r < 90) return 16'($urandom_range(0, room));
    return 16'h0;
  endfunction

  // Mostly well-formed frames; the rest are header errors, line noise ahead
  // of a frame, or a frame broken off early.
  task automatic send_random_frame();
    frame_t      f;
    int          pick;
    int          n;
    logic [15:0] len;
    logic [15:0] room;
    pick = $urandom_range(0, 99);
    len  = pick_length();
    room = len - HdrBytes;
    f    = make_frame(len, TypeData, pick_payload(room));
    if (pick >= 80) begin
      if (pick < 84) begin
        if (frame_limit_m != 16'hffff)
          f.flen = 16'($urandom_range(frame_limit_m + 1, 65535));
        else
          f.mtype = 8'($urandom_range(1, 255));
      end else if (pick < 87) begin
        f.flen = 16'($urandom_range(0, 15));
      end else if (pick < 90) begin
        f.mtype = 8'($urandom_range(1, 255));
      end else if (pick < 93) begin
        f.plen = 16'($urandom_range(room + 1, 65535));
      end else if (pick < 97) begin
        n = $urandom_range(1, 8);
        repeat (n) feed_byte(8'($urandom));
      end else begin
        f.cut = $urandom_range(1, 20);
      end
    end
    send_frame(f);
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Good frames at reset settings: header only, full payload with extreme
  // header fields, payload followed by slack, all slack, one payload byte.
  task automatic test_good_frames();
    frame_t f;
    send_frame(make_frame(16, TypeData, 0));
    f       = make_frame(40, TypeData, 24);
    f.src   = '1;
    f.dst   = '0;
    f.rsv   = '1;
    f.flags = 16'hffff;
    send_frame(f);
    f       = make_frame(30, TypeData, 5);
    f.src   = '0;
    f.dst   = '1;
    f.flags = 16'h0000;
    send_frame(f);
    send_frame(make_frame(20, TypeData, 0));
    send_frame(make_frame(17, TypeData, 1));
  endtask

  // Link and message header errors, including which check wins when several hit.
  task automatic test_header_errors();
    send_frame(make_frame(16'hffff, TypeData, 0));
    send_frame(make_frame(FrameLimitRst + 16'd1, TypeData, 0));
    send_frame(make_frame(16'd0, TypeData, 0));
    send_frame(make_frame(16'd15, TypeData, 0));
    send_frame(make_frame(32, 8'hff, 0));
    send_frame(make_frame(32, 8'h01, 0));
    send_frame(make_frame(16'hffff, 8'h5a, 0));  // too long beats bad type
    send_frame(make_frame(3, 8'h07, 0));         // too short beats bad type
    send_frame(make_frame(32, TypeData, 17));    // payload one past the room
    send_frame(make_frame(16, TypeData, 16'hffff));
    send_frame(make_frame(16, TypeData, 1));
  endtask

  // Hunt behavior: the closing byte of a frame must not pair with the next one,
  // noise and a half sync word ahead of a frame.
  task automatic test_hunt();
    frame_t f;
    f = make_frame(16, TypeData, 0);
    f.flags[15:8] = sync_word_m[7:0];
    send_frame(f);
    feed_byte(sync_word_m[15:8]);
    feed_byte(8'h00);
    feed_byte(8'hff);
    send_frame(make_frame(24, TypeData, 8));
    feed_byte(sync_word_m[7:0]);
    feed_byte(~sync_word_m[15:8]);
    send_frame(make_frame(18, TypeData, 2));
    repeat (5) feed_byte(8'($urandom));
    send_frame(make_frame(22, TypeData, 6));
  endtask

  task automatic test_register_writes();
    write_reg(CfgFrameLimit, 16'd16);
    send_frame(make_frame(16, TypeData, 0));   // exactly at the limit
    send_frame(make_frame(17, TypeData, 1));   // one above it
    write_reg(CfgFrameLimit, 16'd0);           // below the header, nothing passes
    send_frame(make_frame(16, TypeData, 0));
    send_frame(make_frame(0, TypeData, 0));
    write_reg(CfgFrameLimit, 16'hffff);
    send_frame(make_frame(16'hffff, 8'h01, 0));
    send_frame(make_frame(24, TypeData, 8));
    write_reg(CfgSyncWord, 16'h0000);
    send_frame(make_frame(20, TypeData, 4));
    write_reg(CfgSyncWord, 16'hffff);
    send_frame(make_frame(20, TypeData, 3));
    write_reg(CfgSyncWord, 16'($urandom));
    send_frame(make_frame(26, TypeData, 10));
    // writes to unmapped indexes must leave both registers alone
    write_reg(CfgSpareA, 16'h0010);
    write_reg(CfgSpareB, 16'hffff);
    send_frame(make_frame(40, TypeData, 20));
    send_frame(make_frame(600, TypeData, 0));
  endtask

  // Four rounds, each with its own idling and register settings.
  task automatic test_random_frames();
    int round;
    int goal;
    for (round = 0; round < 4; round++) begin
      case (round)
        0: begin
          write_reg(CfgFrameLimit, FrameLimitRst);
          write_reg(CfgSyncWord, SyncWordRst);
          gap_pct   = 0;
          stall_pct = 0;
        end
        1: begin
          write_reg(CfgFrameLimit, 16'hffff);
          write_reg(CfgSyncWord, 16'hffff);
          gap_pct   = 69;
          stall_pct = 0;
        end
        2: begin
          write_reg(CfgFrameLimit, 16'($urandom_range(64, 1024)));
          write_reg(CfgSyncWord, 16'($urandom));
          gap_pct   = 0;
          stall_pct = 69;
        end
        default: begin
          write_reg(CfgFrameLimit, 16'($urandom_range(64, 65535)));
          write_reg(CfgSyncWord, 16'h0000);
          gap_pct   = 30;
          stall_pct = 30;
        end
      endcase
      goal = frame_bytes + RandomBytes / 4;
      while (frame_bytes < goal) send_random_frame();
    end
  endtask

  initial begin
    cfg_we_i      = 1'b0;
    cfg_index_i   = CfgFrameLimit;
    cfg_data_i    = '0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_good_frames();
    test_header_errors();
    test_hunt();
    test_register_writes();
    test_random_frames();
    settle();

    $display("Fed %0d bytes (%0d in frames), checked %0d words; closes ok %0d, too long %0d,",
             bytes_fed, frame_bytes, words_checked, closes_by_status[StOk],
             closes_by_status[StTooLong]);
    $display("bad type %0d, payload too big %0d, too short %0d; idling and registers swept.",
             closes_by_status[StBadType], closes_by_status[StPayBig],
             closes_by_status[StTooShort]);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/slfr_pkg.sv
hdl/slfr_if.sv
hdl/sync_length_frame_receiver_core.sv
tb/sv/tb_top.sv
